FILE: sv/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Holds the channel payload structs, the command passed from the front
// part to the back part, character codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_status;
      logic       malformed;
      logic       last;
   } rsp_item_type;

   // Command kinds queued between front and back
   localparam logic [1:0] KIND_BYTE     = 2'd0;
   localparam logic [1:0] KIND_STATUS   = 2'd1;
   localparam logic [1:0] KIND_VERBATIM = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic        malformed;
      logic [31:0] data;   // byte in [7:0], or four hex chars, first in [31:24]
   } cmd_type;

   // Command queue geometry
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Verbatim expansion: six results, index of the final one
   localparam logic [2:0] VERB_LAST = 3'd5;

   // Character codes
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CTRL_BS        = 8'h08;
   localparam logic [7:0] CTRL_FF        = 8'h0C;
   localparam logic [7:0] CTRL_LF        = 8'h0A;
   localparam logic [7:0] CTRL_CR        = 8'h0D;
   localparam logic [7:0] CTRL_TAB       = 8'h09;

   // Decode one hex character: {valid, digit}
   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] res;
      res = 5'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         res = {1'b1, ch[3:0]};
      end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
         res = {1'b1, ch[3:0] + 4'd9};
      end
      return res;
   endfunction

endpackage

FILE: sv/json_string_unescape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape: streaming JSON string unescaper
// Decodes escaped string bytes into raw bytes plus one status per string.
// ----------------------------------------------------------------------------
//
//  channel  ports                          direction  transfer when
//  req      req_push req_full req_item     in         req_push && !req_full
//  rsp      rsp_pop rsp_empty rsp_item     out        rsp_pop && !rsp_empty
//
//  One item is taken per cycle while req_full is low; its command lands in
//  the queue at the accepting edge and moves on to the output register once
//  it is at the queue head and that register is free, and is taken from there.
//  A \u value of 0x100 or more expands to six results, one per cycle
//  unless rsp stalls, out of a single queued command; items behind it can
//  fill the four-entry command queue, raising req_full till it drains.
//  Reset is synchronous and clears parser state, queue and output register.
//  Stalls on rsp hold the output register; stalls on req hold nothing.
//
module json_string_unescape (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  jsu_pkg::req_item_type req_item,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output jsu_pkg::rsp_item_type rsp_item
);

   logic             accept;
   logic             cmd_push;
   jsu_pkg::cmd_type cmd;
   logic             cmd_pop;
   logic             head_valid;
   jsu_pkg::cmd_type head;

   // Take an item only when its command has room in the queue
   assign accept = req_push && !req_full;

   // Parse escapes and classify each item
   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_item),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   // Buffer commands so the expander can stall on its own
   jsu_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .pop        (cmd_pop),
      .full       (req_full),
      .head_valid (head_valid),
      .head       (head)
   );

   // Expand commands into results and hold the oldest one
   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .cmd_pop    (cmd_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_item   (rsp_item)
   );

endmodule

FILE: sv/jsu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front: escape parser
// Tracks escape state per byte and queues one command for every item that
// yields output: a plain byte, a verbatim \u sequence or the status.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  jsu_pkg::req_item_type item,
   output logic                  cmd_push,
   output jsu_pkg::cmd_type      cmd
);

   localparam logic [1:0] MODE_TEXT = 2'd0;
   localparam logic [1:0] MODE_ESC  = 2'd1;
   localparam logic [1:0] MODE_HEX  = 2'd2;
   localparam logic [1:0] MODE_ERR  = 2'd3;

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [11:0] hex_value_ff, hex_value_in;
   logic [7:0]  held_ff [3];
   logic        held_we;
   logic [4:0]  dig;

   assign dig = jsu_pkg::hex_digit(item.in_byte);

   always_comb begin
      mode_in      = mode_ff;
      hex_count_in = hex_count_ff;
      hex_value_in = hex_value_ff;
      held_we      = 1'b0;
      cmd_push     = 1'b0;
      cmd          = '0;
      if (accept) begin
         if (item.string_end) begin
            cmd_push      = 1'b1;
            cmd.kind      = jsu_pkg::KIND_STATUS;
            cmd.malformed = (mode_ff != MODE_TEXT);
            mode_in       = MODE_TEXT;
            hex_count_in  = 2'd0;
            hex_value_in  = 12'd0;
         end else begin
            case (mode_ff)
               MODE_TEXT: begin
                  if (item.in_byte == jsu_pkg::CHAR_BACKSLASH) begin
                     mode_in = MODE_ESC;
                  end else begin
                     cmd_push       = 1'b1;
                     cmd.kind       = jsu_pkg::KIND_BYTE;
                     cmd.data[7:0]  = item.in_byte;
                  end
               end
               MODE_ESC: begin
                  mode_in  = MODE_TEXT;
                  cmd_push = 1'b1;
                  cmd.kind = jsu_pkg::KIND_BYTE;
                  case (item.in_byte)
                     jsu_pkg::CHAR_QUOTE:     cmd.data[7:0] = jsu_pkg::CHAR_QUOTE;
                     jsu_pkg::CHAR_BACKSLASH: cmd.data[7:0] = jsu_pkg::CHAR_BACKSLASH;
                     jsu_pkg::CHAR_B:         cmd.data[7:0] = jsu_pkg::CTRL_BS;
                     jsu_pkg::CHAR_F:         cmd.data[7:0] = jsu_pkg::CTRL_FF;
                     jsu_pkg::CHAR_N:         cmd.data[7:0] = jsu_pkg::CTRL_LF;
                     jsu_pkg::CHAR_R:         cmd.data[7:0] = jsu_pkg::CTRL_CR;
                     jsu_pkg::CHAR_T:         cmd.data[7:0] = jsu_pkg::CTRL_TAB;
                     jsu_pkg::CHAR_U: begin
                        cmd_push     = 1'b0;
                        mode_in      = MODE_HEX;
                        hex_count_in = 2'd0;
                        hex_value_in = 12'd0;
                     end
                     default: begin
                        cmd_push = 1'b0;
                        mode_in  = MODE_ERR;
                     end
                  endcase
               end
               MODE_HEX: begin
                  if (!dig[4]) begin
                     mode_in = MODE_ERR;
                  end else if (hex_count_ff != 2'd3) begin
                     held_we      = 1'b1;
                     hex_value_in = {hex_value_ff[7:0], dig[3:0]};
                     hex_count_in = hex_count_ff + 2'd1;
                  end else begin
                     cmd_push = 1'b1;
                     // value below 0x100 exactly when the top 8 of the 12 bits are zero
                     if (hex_value_ff[11:4] == 8'd0) begin
                        cmd.kind      = jsu_pkg::KIND_BYTE;
                        cmd.data[7:0] = {hex_value_ff[3:0], dig[3:0]};
                     end else begin
                        cmd.kind = jsu_pkg::KIND_VERBATIM;
                        cmd.data = {held_ff[0], held_ff[1], held_ff[2], item.in_byte};
                     end
                     mode_in      = MODE_TEXT;
                     hex_count_in = 2'd0;
                     hex_value_in = 12'd0;
                  end
               end
               default: begin
                  // error state: drop the byte
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TEXT;
         hex_count_ff <= 2'd0;
         hex_value_ff <= 12'd0;
      end else begin
         mode_ff      <= mode_in;
         hex_count_ff <= hex_count_in;
         hex_value_ff <= hex_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_ff[hex_count_ff] <= item.in_byte;
      end
   end

endmodule

FILE: sv/jsu_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_fifo: command queue
// Short register queue that decouples the parser from the result expander.
// ----------------------------------------------------------------------------
module jsu_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output jsu_pkg::cmd_type head
);

   jsu_pkg::cmd_type                 mem_ff [jsu_pkg::CMD_DEPTH];
   logic [jsu_pkg::CMD_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::CMD_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::CMD_CNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == jsu_pkg::CMD_CNT_W'(jsu_pkg::CMD_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/jsu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back: result expander
// Turns each queued command into one or six results and holds the oldest
// result in an output register until it is taken.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  jsu_pkg::cmd_type      head,
   output logic                  cmd_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output jsu_pkg::rsp_item_type rsp_item
);

   logic                  out_valid_ff, out_valid_in;
   jsu_pkg::rsp_item_type out_ff;
   jsu_pkg::rsp_item_type nxt;
   logic [2:0]            seq_ff, seq_in;
   logic                  advance;

   assign advance   = head_valid && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      nxt = '0;
      case (head.kind)
         jsu_pkg::KIND_STATUS: begin
            nxt.is_status = 1'b1;
            nxt.malformed = head.malformed;
            nxt.last      = 1'b1;
         end
         jsu_pkg::KIND_VERBATIM: begin
            nxt.last = (seq_ff == jsu_pkg::VERB_LAST);
            case (seq_ff)
               3'd0:    nxt.out_byte = jsu_pkg::CHAR_BACKSLASH;
               3'd1:    nxt.out_byte = jsu_pkg::CHAR_U;
               3'd2:    nxt.out_byte = head.data[31:24];
               3'd3:    nxt.out_byte = head.data[23:16];
               3'd4:    nxt.out_byte = head.data[15:8];
               default: nxt.out_byte = head.data[7:0];
            endcase
         end
         default: begin
            nxt.out_byte = head.data[7:0];
            nxt.last     = 1'b1;
         end
      endcase
   end

   always_comb begin
      cmd_pop      = advance && nxt.last;
      out_valid_in = out_valid_ff;
      seq_in       = seq_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         seq_in       = nxt.last ? 3'd0 : seq_ff + 3'd1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         seq_ff       <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         seq_ff       <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= nxt;
      end
   end

`ifndef SYNTH
   a_seq_range: assert property (@(posedge clock) disable iff (reset)
      seq_ff <= jsu_pkg::VERB_LAST)
      else $error("expansion index out of range");

   a_seq_head: assert property (@(posedge clock) disable iff (reset)
      seq_ff != 3'd0 |-> head_valid && head.kind == jsu_pkg::KIND_VERBATIM)
      else $error("expansion in flight without verbatim command");

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.is_status |-> out_ff.last && out_ff.out_byte == 8'd0)
      else $error("status result malformed");

   a_malformed_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.is_status |-> !out_ff.malformed)
      else $error("malformed flag on byte result");
`endif

endmodule

FILE: verif/json_string_unescape_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_check: scoreboard for the JSON string unescaper
// Watches both channels, decodes every accepted input byte with its own
// copy of the escape parser and compares each accepted result, field by
// field, with the oldest unescaped byte or status still waiting.
// ----------------------------------------------------------------------------
module json_string_unescape_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  jsu_pkg::req_item_type req_item,
   input  logic                  rsp_pop,
   input  logic                  rsp_empty,
   input  jsu_pkg::rsp_item_type rsp_item,
   output int                    fail_count,
   output int                    pending,
   output int                    byte_count,
   output int                    status_count,
   output int                    malformed_count
);

   typedef enum logic [1:0] {
      PARSE_TEXT,
      PARSE_ESCAPE,
      PARSE_HEX,
      PARSE_ERROR
   } parse_mode_type;

   localparam logic [15:0] NARROW_LIMIT = 16'h0100;

   parse_mode_type        mode;
   logic [1:0]            digits_seen;
   logic [7:0]            digit_chars [3];
   logic [11:0]           partial_value;
   jsu_pkg::rsp_item_type unescaped_q [$];
   int                    errors;
   int                    bytes_seen;
   int                    statuses_seen;
   int                    malformed_seen;

   initial begin
      fail_count      = 0;
      pending         = 0;
      byte_count      = 0;
      status_count    = 0;
      malformed_count = 0;
      errors          = 0;
      bytes_seen      = 0;
      statuses_seen   = 0;
      malformed_seen  = 0;
   end

   // {valid, value} of one hex digit of either case
   function automatic logic [4:0] nibble_of(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return {1'b1, 4'(ch - "0")};
      if (ch >= "a" && ch <= "f") return {1'b1, 4'(ch - "a" + 8'd10)};
      if (ch >= "A" && ch <= "F") return {1'b1, 4'(ch - "A" + 8'd10)};
      return 5'd0;
   endfunction

   task automatic clear_parser();
      mode          = PARSE_TEXT;
      digits_seen   = 2'd0;
      partial_value = 12'd0;
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic fin);
      unescaped_q.push_back('{out_byte: b, is_status: 1'b0, malformed: 1'b0, last: fin});
   endtask

   task automatic decode_char(input jsu_pkg::req_item_type it);
      logic [4:0]  nib;
      logic [15:0] code_point;
      nib = nibble_of(it.in_byte);
      if (it.string_end) begin
         unescaped_q.push_back('{out_byte: 8'd0, is_status: 1'b1,
                                 malformed: mode != PARSE_TEXT, last: 1'b1});
         clear_parser();
      end else begin
         case (mode)
            PARSE_TEXT: begin
               if (it.in_byte == jsu_pkg::CHAR_BACKSLASH) mode = PARSE_ESCAPE;
               else queue_byte(it.in_byte, 1'b1);
            end
            PARSE_ESCAPE: begin
               mode = PARSE_TEXT;
               case (it.in_byte)
                  jsu_pkg::CHAR_QUOTE:     queue_byte(jsu_pkg::CHAR_QUOTE, 1'b1);
                  jsu_pkg::CHAR_BACKSLASH: queue_byte(jsu_pkg::CHAR_BACKSLASH, 1'b1);
                  jsu_pkg::CHAR_B:         queue_byte(jsu_pkg::CTRL_BS, 1'b1);
                  jsu_pkg::CHAR_F:         queue_byte(jsu_pkg::CTRL_FF, 1'b1);
                  jsu_pkg::CHAR_N:         queue_byte(jsu_pkg::CTRL_LF, 1'b1);
                  jsu_pkg::CHAR_R:         queue_byte(jsu_pkg::CTRL_CR, 1'b1);
                  jsu_pkg::CHAR_T:         queue_byte(jsu_pkg::CTRL_TAB, 1'b1);
                  jsu_pkg::CHAR_U: begin
                     mode          = PARSE_HEX;
                     digits_seen   = 2'd0;
                     partial_value = 12'd0;
                  end
                  default:                 mode = PARSE_ERROR;
               endcase
            end
            PARSE_HEX: begin
               if (!nib[4]) begin
                  mode = PARSE_ERROR;
               end else if (digits_seen != 2'd3) begin
                  digit_chars[digits_seen] = it.in_byte;
                  partial_value = {partial_value[7:0], nib[3:0]};
                  digits_seen++;
               end else begin
                  code_point = {partial_value, nib[3:0]};
                  if (code_point < NARROW_LIMIT) begin
                     queue_byte(code_point[7:0], 1'b1);
                  end else begin
                     // pass the escape on as received
                     queue_byte(jsu_pkg::CHAR_BACKSLASH, 1'b0);
                     queue_byte(jsu_pkg::CHAR_U, 1'b0);
                     queue_byte(digit_chars[0], 1'b0);
                     queue_byte(digit_chars[1], 1'b0);
                     queue_byte(digit_chars[2], 1'b0);
                     queue_byte(it.in_byte, 1'b1);
                  end
                  clear_parser();
               end
            end
            default: ; // drop everything until end of string
         endcase
      end
   endtask

   always @(posedge clock) begin
      jsu_pkg::rsp_item_type want;
      if (reset) begin
         unescaped_q.delete();
         clear_parser();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (unescaped_q.size() == 0) begin
               $error("unexpected result %p", rsp_item);
               errors++;
            end else begin
               want = unescaped_q.pop_front();
               if (rsp_item.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_item.out_byte);
                  errors++;
               end
               if (rsp_item.is_status !== want.is_status) begin
                  $error("is_status: expected %0b, got %0b", want.is_status, rsp_item.is_status);
                  errors++;
               end
               if (rsp_item.malformed !== want.malformed) begin
                  $error("malformed: expected %0b, got %0b", want.malformed, rsp_item.malformed);
                  errors++;
               end
               if (rsp_item.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_item.last);
                  errors++;
               end
               if (want.is_status) begin
                  statuses_seen++;
                  if (want.malformed) malformed_seen++;
               end else begin
                  bytes_seen++;
               end
            end
         end
         if (req_push && !req_full) decode_char(req_item);
      end
      fail_count      <= errors;
      pending         <= unescaped_q.size();
      byte_count      <= bytes_seen;
      status_count    <= statuses_seen;
      malformed_count <= malformed_seen;
   end

endmodule

FILE: verif/json_string_unescape_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_test: top level of the unescaper testbench
// Drives escaped strings into the block, pops results with random stalls
// and one long hold-off, and reports the verdict from the scoreboard.
// ----------------------------------------------------------------------------
module json_string_unescape_test;

   localparam int RESET_CYCLES    = 10;
   localparam int RANDOM_ITEMS    = 90;
   localparam int IDLE_PERCENT    = 11;
   // random strings that start inside this item window run without idling
   localparam int QUIET_FROM      = 35;
   localparam int QUIET_TO        = 75;
   // long enough for the command queue and output register to fill up
   localparam int HOLD_OFF_CYCLES = 80;
   // margin for the result pipeline and a six-byte verbatim expansion
   localparam int DRAIN_CYCLES    = 8;
   // far above the hold-off, the longest legal stretch without a transfer
   localparam int WATCHDOG_LIMIT  = 2000;

   logic                  clock    = 1'b0;
   logic                  reset    = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   jsu_pkg::req_item_type req_item = '0;
   logic                  rsp_pop  = 1'b0;
   logic                  rsp_empty;
   jsu_pkg::rsp_item_type rsp_item;

   int fail_count;
   int pending;
   int byte_count;
   int status_count;
   int malformed_count;
   int items_sent       = 0;
   int stuck_cycles     = 0;
   bit quiet            = 1'b0;   // no idling on either side while set
   bit hold_off_request = 1'b0;   // sender asks the receiver to hold off

   logic [7:0] simple_escapes [7] = '{jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH,
                                      jsu_pkg::CHAR_B, jsu_pkg::CHAR_F,
                                      jsu_pkg::CHAR_N, jsu_pkg::CHAR_R,
                                      jsu_pkg::CHAR_T};

   json_string_unescape dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

   json_string_unescape_check checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_item        (req_item),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_item        (rsp_item),
      .fail_count      (fail_count),
      .pending         (pending),
      .byte_count      (byte_count),
      .status_count    (status_count),
      .malformed_count (malformed_count)
   );

   always #10 clock = ~clock;

   // Hex digit for a nibble, letters in random case
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return "0" + nib;
      return ($urandom_range(1) ? "a" : "A") + nib - 8'd10;
   endfunction

   // Offer one item and hold it until the block takes it. Idle cycles go
   // in front, so a valid that stays high is never dropped in between.
   task automatic offer(input logic [7:0] ch, input logic fin);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_item <= '{in_byte: ch, string_end: fin};
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic offer_text(input string s);
      for (int i = 0; i < s.len(); i++) offer(s[i], 1'b0);
   endtask

   // Receiver: pop at random, and hold off for a long stretch on request
   initial begin : receiver
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_request) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_pop <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge clock);
         end
      end
   end

   // Watchdog: count cycles in which neither channel makes a transfer
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      int          random_start;
      int          n_tokens;
      int          pick;
      int          n_digits;
      logic [15:0] code_point;
      logic [7:0]  ch;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero byte as text, every simple escape, a narrow and a
      // wide \u value, then a clean end of string
      offer(8'h00, 1'b0);
      offer_text("\\\"\\\\\\b\\f\\n\\r\\t");
      offer_text("\\u00Fe");
      offer_text("\\uABcd");
      offer(8'hFF, 1'b1);
      // unknown escape with a zero byte: error state
      offer(jsu_pkg::CHAR_BACKSLASH, 1'b0);
      offer(8'h00, 1'b0);
      offer(8'h00, 1'b1);
      // non-hex digit inside \u, then a byte the error state must drop
      offer_text("\\uGz");
      offer(8'h00, 1'b1);
      // string ends on a pending backslash
      offer(jsu_pkg::CHAR_BACKSLASH, 1'b0);
      offer(8'h00, 1'b1);

      // Random strings: mostly well-formed escapes with random content,
      // some broken or truncated ones
      random_start = items_sent;
      for (int s = 0; items_sent - random_start < RANDOM_ITEMS; s++) begin
         quiet = (items_sent - random_start >= QUIET_FROM) &&
                 (items_sent - random_start < QUIET_TO);
         if (s == 1) hold_off_request = 1'b1;
         n_tokens = $urandom_range(1, 6);
         for (int t = 0; t < n_tokens; t++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               do ch = 8'($urandom_range(255)); while (ch == jsu_pkg::CHAR_BACKSLASH);
               offer(ch, 1'b0);
            end else if (pick < 63) begin
               offer(jsu_pkg::CHAR_BACKSLASH, 1'b0);
               offer(simple_escapes[$urandom_range(6)], 1'b0);
            end else if (pick < 83) begin
               // half narrow values, half wide ones that pass through verbatim
               if ($urandom_range(1)) code_point = 16'($urandom_range(255));
               else code_point = 16'($urandom_range(16'hFFFF, 16'h0100));
               offer(jsu_pkg::CHAR_BACKSLASH, 1'b0);
               offer(jsu_pkg::CHAR_U, 1'b0);
               for (int d = 3; d >= 0; d--) offer(hex_char(code_point[4*d +: 4]), 1'b0);
            end else if (pick < 89) begin
               do ch = 8'($urandom_range(255));
               while (ch inside {jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH,
                                 jsu_pkg::CHAR_B, jsu_pkg::CHAR_F, jsu_pkg::CHAR_N,
                                 jsu_pkg::CHAR_R, jsu_pkg::CHAR_T, jsu_pkg::CHAR_U});
               offer(jsu_pkg::CHAR_BACKSLASH, 1'b0);
               offer(ch, 1'b0);
            end else if (pick < 95) begin
               offer(jsu_pkg::CHAR_BACKSLASH, 1'b0);
               offer(jsu_pkg::CHAR_U, 1'b0);
               n_digits = $urandom_range(3);
               for (int d = 0; d < n_digits; d++) offer(hex_char(4'($urandom_range(15))), 1'b0);
               do ch = 8'($urandom_range(255));
               while (ch inside {["0":"9"], ["a":"f"], ["A":"F"]});
               offer(ch, 1'b0);
            end else begin
               // truncate: end the string inside an escape
               offer(jsu_pkg::CHAR_BACKSLASH, 1'b0);
               if ($urandom_range(1)) begin
                  offer(jsu_pkg::CHAR_U, 1'b0);
                  n_digits = $urandom_range(3);
                  for (int d = 0; d < n_digits; d++)
                     offer(hex_char(4'($urandom_range(15))), 1'b0);
               end
               break;
            end
         end
         // in_byte is ignored on an end item, so fill it at random
         offer(8'($urandom_range(255)), 1'b1);
      end
      req_push <= 1'b0;
      quiet = 1'b0;

      // Drain: wait for every expected result, then a few cycles more
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d input transfers; %0d bytes and %0d end-of-string statuses checked",
               items_sent, byte_count, status_count);
      $display("tb: %0d statuses malformed; one long receiver hold-off with input backpressure",
               malformed_count);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
